### hdl/tkh_pkg.sv
// Shared types and constants for the top-k min-heap selector.
package tkh_pkg;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned POS_W      = 16;
    localparam int unsigned TOPCNT_W   = 5;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_TOP_COUNT   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SORTED_MODE = 8'd1;

    localparam logic [TOPCNT_W-1:0] TOP_COUNT_RST = 5'd10;

    // Datapath operations issued by the controller.
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_WRITE  = 4'd1;  // store incoming word at address
    localparam logic [3:0] OP_RDPAR  = 4'd2;  // read parent into work register
    localparam logic [3:0] OP_RDKIDS = 4'd3;  // read both children
    localparam logic [3:0] OP_SWAP   = 4'd4;  // write parent/child exchange
    localparam logic [3:0] OP_EMIT   = 4'd5;  // read entry for output
    localparam logic [3:0] OP_ROOTSW = 4'd6;  // exchange root and entry
    localparam logic [3:0] OP_TAKE   = 4'd7;  // capture incoming word
    localparam logic [3:0] OP_WRROOT = 4'd8;  // store captured word at address

    typedef struct packed {
        logic [3:0] op;
        logic [6:0] node;     // parent address
        logic [6:0] lft;      // left child address
        logic [6:0] rgt;      // right child address
        logic       rgt_ok;   // right child inside heap
        logic [POS_W-1:0] pos;
    } t_cmd;

    typedef struct packed {
        logic stop;       // parent <= chosen child
        logic pick_rgt;   // right child chosen
        logic greater;    // incoming word beats root
    } t_stat;

endpackage

### hdl/top_k_min_heap_select.sv
// Top level of the top-k min-heap selector: config registers and glue.
//
// Usage: feed one row element per word on the input channel (i_valid,
// o_stall, i_value, i_last). The block keeps the k largest values of the
// row (k = top_count, 0 acts as 1, above K_MAX acts as K_MAX, latched at
// the first element). On the word with i_last high it emits the kept
// values with their row positions on the output channel (o_valid,
// i_stall, o_value_out, o_index_out, o_last_out); o_last_out marks the
// final one. With sorted_mode = 1 they come out in descending order,
// otherwise in heap order. A row shorter than k emits only what arrived.
// Sequence: each of the first k-1 words is stored; the k-th word adds
// the bottom-up heap build. A later word is compared with the root and,
// when it beats the root, replaces it and is sifted down (up to log2(k)
// levels). The end of row adds, in sorted mode, the heap-sort (k-1 root
// swaps, each followed by a sift-down), then the emit of each kept word.
// Everything is paced by the one heap memory port set.
// o_stall is high whenever the sequencer is busy; i_stall holds the
// output register and the drain waits. Configuration writes are taken
// in any cycle (o_cfg_ready is tied high). Synchronous active-low reset
// empties the row, restores top_count=10 and sorted_mode=1.
module top_k_min_heap_select import tkh_pkg::*; #(
    parameter int unsigned K_MAX   = 16,
    parameter int unsigned ROW_MAX = 65536
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [VALUE_W-1:0]    i_value,
    input  logic                  i_last,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [VALUE_W-1:0]    o_value_out,
    output logic [POS_W-1:0]      o_index_out,
    output logic                  o_last_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [TOPCNT_W-1:0] r_top_count;
    logic                r_sorted_mode;
    t_cmd                cmd;
    t_stat               stat;
    logic                ld_out;
    logic                out_last;
    logic                out_busy;

    assign o_cfg_ready = 1'b1;

    // Hold register values; writes land whenever the port strobes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_count   <= TOP_COUNT_RST;
            r_sorted_mode <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TOP_COUNT:   r_top_count   <= i_cfg_data[TOPCNT_W-1:0];
                REG_SORTED_MODE: r_sorted_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Output register is busy if a word sits there and is stalled.
    assign out_busy = o_valid && i_stall;

    tkh_ctrl #(.K_MAX(K_MAX), .ROW_MAX(ROW_MAX)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_last        (i_last),
        .i_top_count   (r_top_count),
        .i_sorted_mode (r_sorted_mode),
        .i_stat        (stat),
        .i_out_busy    (out_busy),
        .o_stall       (o_stall),
        .o_cmd         (cmd),
        .o_ld_out      (ld_out),
        .o_out_last    (out_last)
    );

    tkh_datapath #(.K_MAX(K_MAX)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_value),
        .i_ld_out    (ld_out),
        .i_out_last  (out_last),
        .i_out_stall (i_stall),
        .o_stat      (stat),
        .o_valid     (o_valid),
        .o_value_out (o_value_out),
        .o_index_out (o_index_out),
        .o_last_out  (o_last_out)
    );

endmodule

### hdl/tkh_datapath.sv
// Heap storage, compare logic and output register for the top-k selector.
module tkh_datapath import tkh_pkg::*; #(
    parameter int unsigned K_MAX = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_ld_out,
    input  logic               i_out_last,
    input  logic               i_out_stall,
    output t_stat              o_stat,
    output logic               o_valid,
    output logic [VALUE_W-1:0] o_value_out,
    output logic [POS_W-1:0]   o_index_out,
    output logic               o_last_out
);

    localparam int unsigned AW = (K_MAX > 1) ? $clog2(K_MAX) : 1;

    logic [VALUE_W-1:0] r_hv [K_MAX];
    logic [POS_W-1:0]   r_hp [K_MAX];
    logic [VALUE_W-1:0] r_pv, r_lv, r_rv;
    logic [POS_W-1:0]   r_pp, r_lp, r_rp;
    logic [VALUE_W-1:0] r_iv;
    logic               r_valid;
    logic [VALUE_W-1:0] r_ov;
    logic [POS_W-1:0]   r_op;
    logic               r_ol;
    logic               r_kids_rgt_ok;

    logic [AW-1:0] a_node, a_lft, a_rgt;
    logic          pick_rgt;
    logic [VALUE_W-1:0] cv;
    logic [POS_W-1:0]   cp;
    logic [AW-1:0]      a_pick;

    assign a_node = i_cmd.node[AW-1:0];
    assign a_lft  = i_cmd.lft[AW-1:0];
    assign a_rgt  = i_cmd.rgt[AW-1:0];

    assign pick_rgt = r_kids_rgt_ok && ($signed(r_rv) < $signed(r_lv));
    assign cv       = pick_rgt ? r_rv : r_lv;
    assign cp       = pick_rgt ? r_rp : r_lp;
    assign a_pick   = pick_rgt ? a_rgt : a_lft;

    assign o_stat.pick_rgt = pick_rgt;
    assign o_stat.stop     = $signed(r_pv) <= $signed(cv);
    assign o_stat.greater  = $signed(r_iv) > $signed(r_pv);

    // Heap memory: one or two ports per operation, in clocked blocks.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_WRITE: begin
                r_hv[a_node] <= i_value;
                r_hp[a_node] <= i_cmd.pos;
            end
            OP_TAKE: begin
                r_iv <= i_value;
            end
            OP_WRROOT: begin
                r_hv[a_node] <= r_iv;
                r_hp[a_node] <= i_cmd.pos;
            end
            OP_RDPAR: begin
                r_pv <= r_hv[a_node];
                r_pp <= r_hp[a_node];
            end
            OP_RDKIDS: begin
                r_lv <= r_hv[a_lft];
                r_lp <= r_hp[a_lft];
                r_rv <= r_hv[a_rgt];
                r_rp <= r_hp[a_rgt];
                r_kids_rgt_ok <= i_cmd.rgt_ok;
            end
            OP_SWAP: begin
                r_hv[a_node] <= cv;
                r_hp[a_node] <= cp;
                r_hv[a_pick] <= r_pv;
                r_hp[a_pick] <= r_pp;
            end
            OP_ROOTSW: begin
                // r_pv holds root, r_lv holds entry at lft
                r_hv[a_node] <= r_lv;
                r_hp[a_node] <= r_lp;
                r_hv[a_lft]  <= r_pv;
                r_hp[a_lft]  <= r_pp;
                r_pv <= r_lv;
                r_pp <= r_lp;
            end
            OP_EMIT: begin
                r_ov <= r_hv[a_node];
                r_op <= r_hp[a_node];
                r_ol <= i_out_last;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ld_out) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid     = r_valid;
    assign o_value_out = r_ov;
    assign o_index_out = r_op;
    assign o_last_out  = r_ol;

    ap_ld_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ld_out |-> (!r_valid || !i_out_stall))
        else $error("output register overwritten while held");
    ap_emit_ld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ld_out |-> $past(i_cmd.op) == OP_EMIT)
        else $error("output load without memory read");
    ap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_out_stall) |=> (r_valid && $stable(r_ov) && $stable(r_op)))
        else $error("stalled word changed");

endmodule

### hdl/tkh_ctrl.sv
// Sequencer for fill, heap build, replacement, heap-sort and result drain.
module tkh_ctrl import tkh_pkg::*; #(
    parameter int unsigned K_MAX   = 16,
    parameter int unsigned ROW_MAX = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_last,
    input  logic [TOPCNT_W-1:0] i_top_count,
    input  logic                i_sorted_mode,
    input  t_stat               i_stat,
    input  logic                i_out_busy,
    output logic                o_stall,
    output t_cmd                o_cmd,
    output logic                o_ld_out,
    output logic                o_out_last
);

    localparam int unsigned PW = $clog2(ROW_MAX + 1);
    localparam int unsigned KW = $clog2(K_MAX + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDP   = 4'd1;  // read parent
    localparam logic [3:0] S_RDK   = 4'd2;  // read children
    localparam logic [3:0] S_CMP   = 4'd3;  // compare, swap or stop
    localparam logic [3:0] S_BLD   = 4'd4;  // next build node
    localparam logic [3:0] S_SRTRD = 4'd5;  // read root, or end the sort
    localparam logic [3:0] S_SRTRK = 4'd6;
    localparam logic [3:0] S_SRTSW = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;
    localparam logic [3:0] S_EWAIT = 4'd9;
    localparam logic [3:0] S_REPL  = 4'd10; // root read for replacement
    localparam logic [3:0] S_RDONE = 4'd11; // parent loaded, check input
    localparam logic [3:0] S_RSET  = 4'd12;

    // After a sift-down finishes, where to go.
    localparam logic [1:0] R_IDLE  = 2'd0;
    localparam logic [1:0] R_BUILD = 2'd1;
    localparam logic [1:0] R_SORT  = 2'd2;

    logic [3:0]    r_st, n_st;
    logic [PW-1:0] r_rowpos, n_rowpos;
    logic [KW-1:0] r_k, n_k;
    logic [KW-1:0] r_size, n_size;   // heap size for sift
    logic [6:0]    r_node, n_node;
    logic [KW-1:0] r_bidx, n_bidx;   // build counter
    logic [1:0]    r_ret, n_ret;
    logic          r_fin, n_fin;     // row ended, emit after build/sort
    logic          r_srt, n_srt;
    logic [KW-1:0] r_cnt, n_cnt;     // emit/sort index

    logic [KW-1:0] kclamp;
    logic [KW-1:0] cur_k;
    logic [6:0]    lft, rgt;
    logic          accept;

    always_comb begin
        if (i_top_count == '0) begin
            kclamp = KW'(1);
        end else if (32'(i_top_count) > K_MAX) begin
            kclamp = KW'(K_MAX);
        end else begin
            kclamp = KW'(i_top_count);
        end
    end

    assign cur_k  = (r_rowpos == '0) ? kclamp : r_k;
    assign lft    = 7'((r_node << 1) + 7'd1);
    assign rgt    = 7'((r_node << 1) + 7'd2);
    assign o_stall = (r_st != S_IDLE);
    assign accept  = i_valid && (r_st == S_IDLE);

    always_comb begin
        n_st = r_st; n_rowpos = r_rowpos; n_k = r_k; n_size = r_size;
        n_node = r_node; n_bidx = r_bidx; n_ret = r_ret; n_fin = r_fin;
        n_srt = r_srt; n_cnt = r_cnt;
        o_cmd = '0;
        o_cmd.op = OP_NONE;
        o_cmd.node = r_node;
        o_cmd.lft = lft;
        o_cmd.rgt = rgt;
        o_cmd.rgt_ok = (32'(rgt) < 32'(r_size));
        o_cmd.pos = POS_W'(r_rowpos);
        o_ld_out = 1'b0;
        o_out_last = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (accept) begin
                    n_k = cur_k;
                    n_fin = i_last;
                    n_srt = i_sorted_mode;
                    n_st = S_RSET;
                    if (32'(r_rowpos) < ROW_MAX) begin
                        n_rowpos = r_rowpos + PW'(1);
                        if (32'(r_rowpos) < 32'(cur_k)) begin
                            o_cmd.op = OP_WRITE;
                            o_cmd.node = 7'(r_rowpos);
                            if (32'(r_rowpos) + 1 == 32'(cur_k)) begin
                                n_size = cur_k;
                                n_bidx = KW'(cur_k >> 1);
                                n_st = S_BLD;
                            end
                        end else begin
                            // capture the word, then compare against root
                            o_cmd.op = OP_TAKE;
                            n_node = '0;
                            n_size = cur_k;
                            n_st = S_REPL;
                        end
                    end
                end
            end
            S_REPL: begin
                o_cmd.op = OP_RDPAR;
                o_cmd.node = '0;
                n_st = S_RDONE;
            end
            S_RDONE: begin
                // incoming word was captured at accept
                if (i_stat.greater) begin
                    o_cmd.op = OP_WRROOT;
                    o_cmd.node = '0;
                    o_cmd.pos = POS_W'(r_rowpos - PW'(1));
                    n_ret = R_IDLE;
                    n_st = S_RDP;
                end else begin
                    n_st = S_RSET;
                end
            end
            S_BLD: begin
                if (r_bidx == '0) begin
                    n_st = S_RSET;
                end else begin
                    n_bidx = r_bidx - KW'(1);
                    n_node = 7'(r_bidx - KW'(1));
                    n_ret = R_BUILD;
                    n_st = S_RDP;
                end
            end
            S_RDP: begin
                if (32'(lft) >= 32'(r_size)) begin
                    n_st = (r_ret == R_BUILD) ? S_BLD :
                           (r_ret == R_SORT) ? S_SRTRD : S_RSET;
                end else begin
                    o_cmd.op = OP_RDPAR;
                    n_st = S_RDK;
                end
            end
            S_RDK: begin
                o_cmd.op = OP_RDKIDS;
                n_st = S_CMP;
            end
            S_CMP: begin
                if (i_stat.stop) begin
                    n_st = (r_ret == R_BUILD) ? S_BLD :
                           (r_ret == R_SORT) ? S_SRTRD : S_RSET;
                end else begin
                    o_cmd.op = OP_SWAP;
                    n_node = i_stat.pick_rgt ? rgt : lft;
                    n_st = S_RDP;
                end
            end
            S_RSET: begin
                // decide on end of row
                if (r_fin) begin
                    if (32'(r_rowpos) < 32'(r_k)) begin
                        n_size = KW'(r_rowpos);
                        n_bidx = KW'(r_rowpos >> 1);
                        n_k = KW'(r_rowpos);
                        n_st = S_BLD;
                    end else begin
                        n_cnt = r_k;
                        n_fin = 1'b0;
                        n_st = r_srt ? S_SRTRD : S_EMIT;
                        n_size = r_k;
                        if (!r_srt) n_cnt = '0;
                    end
                end else begin
                    n_st = S_IDLE;
                end
            end
            S_SRTRD: begin
                if (r_cnt <= KW'(1)) begin
                    n_cnt = '0;
                    n_st = S_EMIT;
                end else begin
                    n_cnt = r_cnt - KW'(1);
                    o_cmd.op = OP_RDPAR;
                    o_cmd.node = '0;
                    n_st = S_SRTRK;
                end
            end
            S_SRTRK: begin
                o_cmd.op = OP_RDKIDS;
                o_cmd.lft = 7'(r_cnt);
                o_cmd.rgt = 7'(r_cnt);
                n_st = S_SRTSW;
            end
            S_SRTSW: begin
                o_cmd.op = OP_ROOTSW;
                o_cmd.node = '0;
                o_cmd.lft = 7'(r_cnt);
                n_node = '0;
                n_size = r_cnt;
                n_ret = R_SORT;
                n_st = S_RDP;
            end
            S_EMIT: begin
                if (!i_out_busy) begin
                    o_cmd.op = OP_EMIT;
                    o_cmd.node = 7'(r_cnt);
                    o_out_last = (r_cnt + KW'(1) == r_k);
                    n_st = S_EWAIT;
                end
            end
            S_EWAIT: begin
                o_ld_out = 1'b1;
                if (r_cnt + KW'(1) == r_k) begin
                    n_rowpos = '0;
                    n_st = S_IDLE;
                end else begin
                    n_cnt = r_cnt + KW'(1);
                    n_st = S_EMIT;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_rowpos <= '0;
            r_k <= KW'(K_MAX);
            r_fin <= 1'b0;
        end else begin
            r_st <= n_st;
            r_rowpos <= n_rowpos;
            r_k <= n_k;
            r_fin <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size <= n_size;
        r_node <= n_node;
        r_bidx <= n_bidx;
        r_ret <= n_ret;
        r_srt <= n_srt;
        r_cnt <= n_cnt;
    end

    ap_idle_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_st != S_IDLE)
        else $error("accepted word left controller idle");
    ap_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_k != '0 && 32'(r_k) <= K_MAX))
        else $error("latched k out of range");
    ap_emit_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_EMIT) |-> r_cnt < r_k)
        else $error("emit index past heap");

endmodule

### dv/top_k_min_heap_select_chk.sv
`timescale 1ns / 1ps
// Checker for the top-k min-heap selector: predicts kept words per row and compares.
module top_k_min_heap_select_chk import tkh_pkg::*; #(
    parameter int unsigned K_MAX   = 16,
    parameter int unsigned ROW_MAX = 65536
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_in_stall,
    input  logic [VALUE_W-1:0]    i_value,
    input  logic                  i_last,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [VALUE_W-1:0]    i_value_out,
    input  logic [POS_W-1:0]      i_index_out,
    input  logic                  i_last_out,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_rows_done
);
    typedef struct packed {
        logic signed [VALUE_W-1:0] val;
        logic [POS_W-1:0]          pos;
        logic                      lst;
    } t_kept;

    logic [TOPCNT_W-1:0]       top_count;
    logic                      sorted_mode;
    logic signed [VALUE_W-1:0] kept_val [K_MAX];
    logic [POS_W-1:0]          kept_pos [K_MAX];
    int unsigned               row_pos;
    int unsigned               row_k;
    t_kept                     kept_q[$];

    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic signed [VALUE_W-1:0] tv;
        logic [POS_W-1:0]          tp;
        tv = kept_val[a]; tp = kept_pos[a];
        kept_val[a] = kept_val[b]; kept_pos[a] = kept_pos[b];
        kept_val[b] = tv; kept_pos[b] = tp;
    endfunction

    function automatic void sink(int unsigned size, int unsigned node);
        int unsigned pick;
        while (2 * node + 1 < size) begin
            pick = 2 * node + 1;
            if (pick + 1 < size && kept_val[pick + 1] < kept_val[pick]) pick = pick + 1;
            if (kept_val[node] <= kept_val[pick]) break;
            swap_slots(node, pick);
            node = pick;
        end
    endfunction

    function automatic void heapify(int unsigned size);
        for (int i = int'(size / 2) - 1; i >= 0; i--) sink(size, i);
    endfunction

    function automatic void take_word(logic signed [VALUE_W-1:0] v, logic lst);
        int unsigned n;
        if (row_pos == 0) begin
            row_k = (top_count == 0) ? 1 : (top_count > K_MAX ? K_MAX : top_count);
        end
        if (row_pos < ROW_MAX) begin
            if (row_pos < row_k) begin
                kept_val[row_pos] = v;
                kept_pos[row_pos] = row_pos[POS_W-1:0];
                if (row_pos + 1 == row_k) heapify(row_k);
            end else if (v > kept_val[0]) begin
                kept_val[0] = v;
                kept_pos[0] = row_pos[POS_W-1:0];
                sink(row_k, 0);
            end
            row_pos++;
        end
        if (!lst) return;
        n = (row_pos < row_k) ? row_pos : row_k;
        if (n < row_k) heapify(n);
        if (sorted_mode) begin
            for (int unsigned i = n - 1; i >= 1; i--) begin
                swap_slots(0, i);
                sink(i, 0);
            end
        end
        for (int unsigned i = 0; i < n; i++) kept_q.push_back({kept_val[i], kept_pos[i], i + 1 == n});
        row_pos = 0;
    endfunction

    always @(posedge i_clk) begin
        t_kept want;
        if (!i_rst_n) begin
            top_count   <= TOP_COUNT_RST;
            sorted_mode <= 1'b1;
            row_pos     = 0;
            row_k       = K_MAX;
            kept_q.delete();
            o_fail_count <= 0;
            o_rows_done  <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_TOP_COUNT) top_count <= i_cfg_data[TOPCNT_W-1:0];
                else if (i_cfg_index == REG_SORTED_MODE) sorted_mode <= i_cfg_data[0];
            end
            if (i_valid && !i_in_stall) begin
                take_word(i_value, i_last);
                if (i_last) o_rows_done <= o_rows_done + 1;
            end
            if (i_out_valid && !i_out_stall) begin
                if (kept_q.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("unexpected word: value %0d index %0d last %0b",
                                 $signed(i_value_out), i_index_out, i_last_out);
                end else begin
                    want = kept_q.pop_front();
                    if (want.val !== i_value_out || want.pos !== i_index_out
                        || want.lst !== i_last_out) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display("mismatch: exp %0d/%0d/%0b got %0d/%0d/%0b",
                                     want.val, want.pos, want.lst, $signed(i_value_out),
                                     i_index_out, i_last_out);
                    end
                end
            end
        end
        o_pending <= kept_q.size();
    end
endmodule

### dv/top_k_min_heap_select_tb.sv
`timescale 1ns / 1ps
// Testbench top for the top-k min-heap selector: stimulus, config phases and verdict.
module top_k_min_heap_select_tb;
    import tkh_pkg::*;

    localparam int unsigned WATCH_LIMIT = 20000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [VALUE_W-1:0]    i_value;
    logic                  i_last;
    logic                  o_valid;
    logic                  i_stall;
    logic [VALUE_W-1:0]    o_value_out;
    logic [POS_W-1:0]      o_index_out;
    logic                  o_last_out;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    fail_count;
    int                    pending;
    int                    rows_done;
    int                    words_sent;
    int                    idle_cycles;
    bit                    drain_stall_on;

    top_k_min_heap_select DUT (.*);

    top_k_min_heap_select_chk u_chk (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_value, .i_last,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_value_out(o_value_out),
        .i_index_out(o_index_out), .i_last_out(o_last_out), .i_cfg_valid,
        .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending), .o_rows_done(rows_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: count cycles where no word moves on any channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("watchdog expired");
            $display("TEST FAILED");
            $finish;
        end
    end

    // Output side: once drain stalls are on, draw a stall run of random length per word, mostly none.
    initial begin
        int hold;
        i_stall = 1'b1;
        @(posedge i_clk iff i_rst_n);
        forever begin
            hold = (drain_stall_on && $urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk iff o_valid);
        end
    end

    // Write one register; hold until the port takes it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Send one word with a random gap ahead of it; advance once it is taken.
    task automatic send_word(input logic [VALUE_W-1:0] v, input logic lst, input bit gaps);
        int gap;
        gap = (gaps && $urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        i_last  <= lst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        words_sent++;
    endtask

    // Wait until every kept word of the closed rows is out, then let the block settle.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // Random row: mix of full-range values, narrow ranges with ties and extremes.
    task automatic rand_row(input int len, input bit gaps);
        logic [VALUE_W-1:0] v;
        int style;
        style = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) begin
            case (style)
                0: v = $urandom();
                1: v = $urandom_range(0, 7) - 4;
                2: v = ($urandom_range(0, 1) ? 32'h7fff_fff0 : 32'h8000_0000) + $urandom_range(0, 15);
                default: v = $urandom_range(0, 1000) * ($urandom_range(0, 1) ? 1 : -1);
            endcase
            send_word(v, i == len - 1, gaps);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_value     = '0;
        i_last      = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        words_sent  = 0;
        idle_cycles = 0;
        drain_stall_on = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, extremes, a single-word row.
        send_word(32'h7fff_ffff, 1'b0, 1'b0);
        send_word(32'h8000_0000, 1'b0, 1'b0);
        send_word(32'h0000_0000, 1'b0, 1'b0);
        send_word(32'hffff_ffff, 1'b0, 1'b0);
        send_word(32'h0000_0001, 1'b1, 1'b0);   // short row of 5 against k=10
        send_word(32'h1234_5678, 1'b1, 1'b0);   // one-word row
        settle();
        // k of 0 acts as 1, heap order.
        write_reg(REG_TOP_COUNT, 32'd0);
        write_reg(REG_SORTED_MODE, 32'd0);
        for (int i = 0; i < 5; i++) send_word(i * 3 - 6, i == 4, 1'b0);
        settle();
        // Above K_MAX clamps; stray upper data bits are dropped.
        write_reg(REG_TOP_COUNT, 32'hffff_ffff);
        write_reg(REG_SORTED_MODE, 32'hffff_fffe);
        for (int i = 0; i < 10; i++) send_word(32'h5555_5555 ^ (i << 28), i == 9, 1'b0);
        settle();
        write_reg(8'd7, 32'd3);                  // unknown index: no effect

        // Random phases with idling on both sides.
        drain_stall_on = 1'b1;
        while (words_sent < 250) begin
            write_reg(REG_TOP_COUNT, $urandom_range(0, 31));
            write_reg(REG_SORTED_MODE, $urandom_range(0, 1));
            repeat ($urandom_range(1, 4)) begin
                // mostly rows around k, sometimes long or tiny
                rand_row($urandom_range(0, 4) == 0 ? $urandom_range(1, 3)
                                                   : $urandom_range(4, 40),
                         $urandom_range(0, 3) != 0);
            end
            settle();
        end
        write_reg(REG_TOP_COUNT, 32'd16);
        write_reg(REG_SORTED_MODE, 32'd1);
        rand_row(48, 1'b1);
        settle();

        $display("Sent %0d words in %0d rows, k from 0 to 31 in both output orders.",
                 words_sent, rows_done);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
